@@ sv/mmbd_pkg.sv @@
// Shared types, codes and constants for the multi-mode byte descrambler.
// No dependencies; every other file but mmbd_ram refers to it by scoped names.

package mmbd_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CycW   = 3;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableAw = 8;

  localparam logic [CmdW-1:0] CMD_DATA    = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD    = 2'd1;
  localparam logic [CmdW-1:0] CMD_RESTART = 2'd2;

  localparam logic [ModeW-1:0] MODE_FIXED   = 3'd0;
  localparam logic [ModeW-1:0] MODE_CYCLIC  = 3'd1;
  localparam logic [ModeW-1:0] MODE_TABLE   = 3'd2;
  localparam logic [ModeW-1:0] MODE_XOR_SUB = 3'd3;
  localparam logic [ModeW-1:0] MODE_RUNNING = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_MODE        = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_KEY = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DATA_LENGTH = 2'd2;

  localparam logic [ByteW-1:0] FIXED_MASK = 8'h84;
  localparam logic [ByteW-1:0] SUB_MASK   = 8'h85;
  localparam logic [WordW-1:0] KEY_ADD    = 32'h5D58_8B65;
  localparam logic [CycW-1:0]  CYCLE_LAST = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] initial_key;
    logic [WordW-1:0] data_length;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [TableAw-1:0] waddr;
    logic [ByteW-1:0]   wdata;
    logic               re;
    logic [TableAw-1:0] raddr;
  } ram_req_t;

  function automatic logic [ByteW-1:0] cycle_key(input logic [CycW-1:0] idx);
    logic [ByteW-1:0] k;
    unique case (idx)
      3'd0:    k = 8'h79;
      3'd1:    k = 8'h57;
      3'd2:    k = 8'h0d;
      3'd3:    k = 8'h80;
      3'd4:    k = 8'h04;
      default: k = 8'h79;
    endcase
    return k;
  endfunction

endpackage

@@ sv/mmbd_intf.sv @@
// Valid/ready channel interfaces: input item, result item, register write.
// Depends on mmbd_pkg for field widths.

interface mmbd_item_if;
  logic                         valid;
  logic                         ready;
  logic [mmbd_pkg::CmdW-1:0]    cmd;
  logic [mmbd_pkg::ByteW-1:0]   in_byte;
  logic [mmbd_pkg::TableAw-1:0] table_index;
  modport source (output valid, cmd, in_byte, table_index, input ready);
  modport sink (input valid, cmd, in_byte, table_index, output ready);
endinterface

interface mmbd_result_if;
  logic                       valid;
  logic                       ready;
  logic [mmbd_pkg::ByteW-1:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

interface mmbd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mmbd_pkg::CfgIdxW-1:0] index;
  logic [mmbd_pkg::WordW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/multi_mode_byte_descrambler.sv @@
// Top level of the multi-mode byte descrambler.
// Depends on mmbd_pkg, the channel interfaces, mmbd_cfg_regs, mmbd_engine, mmbd_ram.

// Takes one item per clock unless stalled and, for a data item, presents its
// descrambled byte through the input stage with the table read, then the result
// register; load and restart items give no result. The rate is one item per
// cycle unless stalled, set by the single stage that does the table lookup result
// and the mode 4 8x32 multiply-add. The table needs no clearing pass: an entry
// holds garbage until loaded. Write registers only while no item is in flight.

module multi_mode_byte_descrambler (
  input  logic          clk,
  input  logic          rst,
  mmbd_item_if.sink     item,
  mmbd_result_if.source result,
  mmbd_cfg_if.sink      cfg
);

  mmbd_pkg::cfg_t             regs;
  mmbd_pkg::ram_req_t         ram_req;
  logic [mmbd_pkg::ByteW-1:0] ram_rdata;

  mmbd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mmbd_ram #(
    .WIDTH (mmbd_pkg::ByteW),
    .DEPTH (mmbd_pkg::TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  mmbd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .regs      (regs),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ sv/mmbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mmbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mmbd_cfg_regs.sv @@
// Configuration register file: mode, initial key, data length.
// Depends on mmbd_pkg and the mmbd_cfg_if interface.

module mmbd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  mmbd_cfg_if.sink          cfg,
  output mmbd_pkg::cfg_t    regs
);

  always_comb cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        mmbd_pkg::REG_MODE:        regs.mode <= cfg.data[mmbd_pkg::ModeW-1:0];
        mmbd_pkg::REG_INITIAL_KEY: regs.initial_key <= cfg.data;
        mmbd_pkg::REG_DATA_LENGTH: regs.data_length <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/mmbd_engine.sv @@
// Descrambling pipeline: input stage, key/position state, result register.
// Depends on mmbd_pkg and the item/result interfaces; reads the table RAM.

module mmbd_engine (
  input  logic                       clk,
  input  logic                       rst,
  mmbd_item_if.sink                  item,
  mmbd_result_if.source              result,
  input  mmbd_pkg::cfg_t             regs,
  output mmbd_pkg::ram_req_t         ram_req,
  input  logic [mmbd_pkg::ByteW-1:0] ram_rdata
);

  logic                          item_fire;
  logic                          s1_valid;
  logic [mmbd_pkg::CmdW-1:0]     s1_cmd;
  logic [mmbd_pkg::ByteW-1:0]    s1_byte;
  logic                          s1_data;
  logic                          s1_adv;
  logic                          out_free;
  logic [mmbd_pkg::WordW-1:0]    running_key;
  logic [mmbd_pkg::WordW-1:0]    byte_position;
  logic [mmbd_pkg::CycW-1:0]     cycle_index;
  logic [mmbd_pkg::CycW-1:0]     cycle_index_next;
  logic [mmbd_pkg::WordW-1:0]    weight;
  logic [mmbd_pkg::WordW-1:0]    product;
  logic [mmbd_pkg::WordW-1:0]    running_key_next;
  logic [mmbd_pkg::ByteW-1:0]    plain;

  assign item_fire  = item.valid && item.ready;
  assign s1_data    = s1_cmd == mmbd_pkg::CMD_DATA;
  assign out_free   = !result.valid || result.ready;
  assign s1_adv     = s1_valid && (!s1_data || out_free);
  assign item.ready = !s1_valid || s1_adv;

  always_comb begin
    ram_req.we    = item_fire && (item.cmd == mmbd_pkg::CMD_LOAD);
    ram_req.waddr = item.table_index;
    ram_req.wdata = item.in_byte;
    ram_req.re    = item_fire;
    ram_req.raddr = item.in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_cmd  <= item.cmd;
      s1_byte <= item.in_byte;
    end
  end

  assign weight  = regs.data_length - byte_position;
  assign product = {24'd0, s1_byte} * weight;
  assign running_key_next = (running_key ^ {24'd0, s1_byte}) + product + mmbd_pkg::KEY_ADD;
  assign cycle_index_next = (cycle_index == mmbd_pkg::CYCLE_LAST) ? '0 : cycle_index + 3'd1;

  always_comb begin
    unique case (regs.mode)
      mmbd_pkg::MODE_FIXED:   plain = s1_byte ^ mmbd_pkg::FIXED_MASK;
      mmbd_pkg::MODE_CYCLIC:  plain = s1_byte ^ mmbd_pkg::cycle_key(cycle_index);
      mmbd_pkg::MODE_TABLE:   plain = ram_rdata ^ mmbd_pkg::FIXED_MASK;
      mmbd_pkg::MODE_XOR_SUB: plain = (s1_byte ^ mmbd_pkg::SUB_MASK) - 8'd1;
      mmbd_pkg::MODE_RUNNING: plain = s1_byte ^ running_key_next[mmbd_pkg::ByteW-1:0];
      default:                plain = s1_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_key   <= '0;
      byte_position <= '0;
      cycle_index   <= '0;
    end else if (s1_adv) begin
      if (s1_cmd == mmbd_pkg::CMD_RESTART) begin
        running_key   <= regs.initial_key;
        byte_position <= '0;
        cycle_index   <= '0;
      end else if (s1_data) begin
        byte_position <= byte_position + 32'd1;
        if (regs.mode == mmbd_pkg::MODE_RUNNING) begin
          running_key <= running_key_next;
        end
        if (regs.mode == mmbd_pkg::MODE_CYCLIC) begin
          cycle_index <= cycle_index_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv && s1_data) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data) begin
      result.out_byte <= plain;
    end
  end

endmodule

@@ sv/mmbd_checker.sv @@
// Port-level checks of the descrambler's flow control, bound to the top level.
// Depends on mmbd_pkg for the command codes.

module mmbd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic [mmbd_pkg::CmdW-1:0]  item_cmd,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [mmbd_pkg::ByteW-1:0] out_byte
);

  logic data_fire;
  assign data_fire = item_valid && item_ready && (item_cmd == mmbd_pkg::CMD_DATA);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(out_byte))
    else $error("result payload changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input blocked with an empty result register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(data_fire, 2))
    else $error("result without a data transfer two cycles earlier");

endmodule

bind multi_mode_byte_descrambler mmbd_checker u_mmbd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_cmd     (item.cmd),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_byte     (result.out_byte)
);

@@ sim/multi_mode_byte_descrambler_test.sv @@
// Self-checking bench for multi_mode_byte_descrambler: directed and random item
// streams in every mode, checked transfer by transfer against an in-bench model.
// Depends on mmbd_pkg, the channel interfaces and the descrambler RTL.
`timescale 1ns / 1ps

class descramble_scoreboard;
  logic [mmbd_pkg::ModeW-1:0] mode;
  logic [mmbd_pkg::WordW-1:0] initial_key;
  logic [mmbd_pkg::WordW-1:0] data_length;
  logic [mmbd_pkg::ByteW-1:0] sub_table [256];
  logic [mmbd_pkg::WordW-1:0] running_key;
  logic [mmbd_pkg::WordW-1:0] byte_pos;
  int unsigned                cyc;
  logic [mmbd_pkg::ByteW-1:0] cycle_bytes [5];
  logic [mmbd_pkg::ByteW-1:0] plain_bytes_due [$];
  int unsigned                errors;

  function new();
    mode = '0;
    initial_key = '0;
    data_length = '0;
    running_key = '0;
    byte_pos = '0;
    cyc = 0;
    errors = 0;
    cycle_bytes = '{8'h79, 8'h57, 8'h0d, 8'h80, 8'h04};
  endfunction

  function int unsigned pending();
    return plain_bytes_due.size();
  endfunction

  function void set_reg(logic [mmbd_pkg::CfgIdxW-1:0] idx, logic [mmbd_pkg::WordW-1:0] data);
    case (idx)
      mmbd_pkg::REG_MODE:        mode = data[mmbd_pkg::ModeW-1:0];
      mmbd_pkg::REG_INITIAL_KEY: initial_key = data;
      mmbd_pkg::REG_DATA_LENGTH: data_length = data;
      default: ;
    endcase
  endfunction

  function void note_item(logic [mmbd_pkg::CmdW-1:0] cmd, logic [mmbd_pkg::ByteW-1:0] b,
                          logic [mmbd_pkg::TableAw-1:0] idx);
    logic [mmbd_pkg::ByteW-1:0] plain;
    logic [mmbd_pkg::WordW-1:0] weight;
    case (cmd)
      mmbd_pkg::CMD_LOAD: sub_table[idx] = b;
      mmbd_pkg::CMD_RESTART: begin
        running_key = initial_key;
        byte_pos = '0;
        cyc = 0;
      end
      mmbd_pkg::CMD_DATA: begin
        byte_pos = byte_pos + 32'd1;
        case (mode)
          mmbd_pkg::MODE_FIXED:   plain = b ^ 8'h84;
          mmbd_pkg::MODE_CYCLIC: begin
            plain = b ^ cycle_bytes[cyc];
            cyc = (cyc == 4) ? 0 : cyc + 1;
          end
          mmbd_pkg::MODE_TABLE:   plain = sub_table[b] ^ 8'h84;
          mmbd_pkg::MODE_XOR_SUB: plain = (b ^ 8'h85) - 8'd1;
          mmbd_pkg::MODE_RUNNING: begin
            weight = data_length + 32'd1 - byte_pos;
            running_key = running_key ^ {24'd0, b};
            running_key = running_key + {24'd0, b} * weight + 32'h5D58_8B65;
            plain = b ^ running_key[7:0];
          end
          default: plain = b;
        endcase
        plain_bytes_due.push_back(plain);
      end
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [mmbd_pkg::ByteW-1:0] got);
    logic [mmbd_pkg::ByteW-1:0] want;
    if (plain_bytes_due.size() == 0) begin
      report($sformatf("unexpected result, out_byte %02h", got));
    end else begin
      want = plain_bytes_due.pop_front();
      if (got !== want)
        report($sformatf("out_byte got %02h, expected %02h", got, want));
    end
  endtask
endclass

module multi_mode_byte_descrambler_test;

  localparam logic [mmbd_pkg::CmdW-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [mmbd_pkg::ModeW-1:0] MODE_SPARE = 3'd5;
  localparam int unsigned      DRAIN      = 6;
  localparam int unsigned      PHASES     = 18;
  localparam int unsigned      PHASE_ITEMS = 75;

  logic clk;
  logic rst;

  mmbd_item_if   item_ch ();
  mmbd_result_if res_ch ();
  mmbd_cfg_if    cfg_ch ();

  multi_mode_byte_descrambler u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  descramble_scoreboard sb;

  logic [mmbd_pkg::ModeW-1:0]   cur_mode;
  bit                           loaded [256];
  logic [mmbd_pkg::TableAw-1:0] loaded_list [$];
  int unsigned        burst_left;
  int unsigned        max_gap;
  int unsigned        rx_style;
  int unsigned        rx_tick;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_style)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= ((rx_tick % 9) < 6);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        sb.note_item(item_ch.cmd, item_ch.in_byte, item_ch.table_index);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.out_byte);
    end
  end

  task automatic send_item(input logic [mmbd_pkg::CmdW-1:0] c,
                           input logic [mmbd_pkg::ByteW-1:0] b,
                           input logic [mmbd_pkg::TableAw-1:0] x);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (c == mmbd_pkg::CMD_LOAD && !loaded[x]) begin
      loaded[x] = 1'b1;
      loaded_list.push_back(x);
    end
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= c;
    item_ch.in_byte     <= b;
    item_ch.table_index <= x;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mmbd_pkg::CfgIdxW-1:0] idx,
                           input logic [mmbd_pkg::WordW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [mmbd_pkg::ModeW-1:0] m,
                           input logic [mmbd_pkg::WordW-1:0] key,
                           input logic [mmbd_pkg::WordW-1:0] len,
                           input bit wr_key, input bit wr_len);
    settle();
    cur_mode = m;
    write_reg(mmbd_pkg::REG_MODE, {{(mmbd_pkg::WordW-mmbd_pkg::ModeW){1'b0}}, m});
    if (wr_key) write_reg(mmbd_pkg::REG_INITIAL_KEY, key);
    if (wr_len) write_reg(mmbd_pkg::REG_DATA_LENGTH, len);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [mmbd_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 120);
      default: return $urandom();
    endcase
  endfunction

  function automatic void random_item(output logic [mmbd_pkg::CmdW-1:0] c,
                                      output logic [mmbd_pkg::ByteW-1:0] b,
                                      output logic [mmbd_pkg::TableAw-1:0] x);
    int unsigned roll;
    int unsigned load_pct;
    roll = $urandom_range(0, 99);
    load_pct = (cur_mode == mmbd_pkg::MODE_TABLE) ? 30 : 12;
    b = mmbd_pkg::ByteW'($urandom_range(0, 255));
    x = mmbd_pkg::TableAw'($urandom_range(0, 255));
    c = mmbd_pkg::CMD_DATA;
    if (roll < 3)
      c = CMD_SPARE;
    else if (roll < 9)
      c = mmbd_pkg::CMD_RESTART;
    else if (roll < 9 + load_pct ||
             (cur_mode == mmbd_pkg::MODE_TABLE && loaded_list.size() == 0))
      c = mmbd_pkg::CMD_LOAD;
    else if (cur_mode == mmbd_pkg::MODE_TABLE)
      b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  initial begin
    logic [mmbd_pkg::CmdW-1:0]    c;
    logic [mmbd_pkg::ByteW-1:0]   b;
    logic [mmbd_pkg::TableAw-1:0] x;
    int unsigned        counted;
    int unsigned        gap_pick;

    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = mmbd_pkg::CMD_DATA;
    item_ch.in_byte     = '0;
    item_ch.table_index = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = mmbd_pkg::REG_MODE;
    cfg_ch.data         = '0;
    res_ch.ready        = 1'b0;
    rx_tick             = 0;
    rx_style            = 1;
    max_gap             = 3;
    burst_left          = 0;
    cur_mode            = mmbd_pkg::MODE_FIXED;
    sb = new();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    configure(mmbd_pkg::MODE_FIXED, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1);
    send_item(mmbd_pkg::CMD_DATA, 8'h00, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'hFF, 8'hFF);
    send_item(CMD_SPARE, 8'hFF, 8'hFF);
    send_item(mmbd_pkg::CMD_LOAD, 8'hFF, 8'h00);
    send_item(mmbd_pkg::CMD_LOAD, 8'h00, 8'hFF);
    send_item(mmbd_pkg::CMD_LOAD, 8'h5A, 8'h80);
    send_item(mmbd_pkg::CMD_LOAD, 8'hA5, 8'h7F);
    send_item(mmbd_pkg::CMD_RESTART, 8'h00, 8'h00);

    configure(mmbd_pkg::MODE_CYCLIC, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(mmbd_pkg::CMD_DATA, 8'h00, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'hFF, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h11, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h22, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h33, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h44, 8'h00);

    configure(mmbd_pkg::MODE_TABLE, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(mmbd_pkg::CMD_DATA, 8'h00, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'hFF, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h80, 8'h00);

    configure(mmbd_pkg::MODE_XOR_SUB, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(mmbd_pkg::CMD_DATA, 8'h00, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'hFF, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h85, 8'h00);

    configure(mmbd_pkg::MODE_RUNNING, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(mmbd_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'hFF, 8'h00);
    send_item(mmbd_pkg::CMD_DATA, 8'h00, 8'h00);
    // new key must not apply before the next restart
    configure(mmbd_pkg::MODE_RUNNING, 32'h0, 32'h0, 1'b1, 1'b0);
    send_item(mmbd_pkg::CMD_DATA, 8'h01, 8'h00);

    configure(MODE_SPARE, 32'h0, 32'h0, 1'b0, 1'b0);
    send_item(mmbd_pkg::CMD_DATA, 8'hA5, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      rx_style = $urandom_range(0, 2);
      gap_pick = $urandom_range(0, 2);
      max_gap = (gap_pick == 0) ? 0 : (gap_pick == 1) ? 2 : 7;
      configure((p < 10) ? mmbd_pkg::ModeW'(p % 5) : mmbd_pkg::ModeW'($urandom_range(0, 7)),
                pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1))
        send_item(mmbd_pkg::CMD_RESTART, mmbd_pkg::ByteW'($urandom_range(0, 255)),
                  mmbd_pkg::TableAw'($urandom_range(0, 255)));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_item(c, b, x);
        send_item(c, b, x);
        if (c != CMD_SPARE) counted++;
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mmbd_pkg.sv
sv/mmbd_intf.sv
sv/mmbd_ram.sv
sv/mmbd_cfg_regs.sv
sv/mmbd_engine.sv
sv/multi_mode_byte_descrambler.sv
sv/mmbd_checker.sv
sim/multi_mode_byte_descrambler_test.sv
